// File: rtl/bpg_pkg.sv
// Shared types and constants for the beep pattern generator.
// No dependencies; imported by bpg_timer and beep_pattern_generator.
`default_nettype none

package bpg_pkg;

  // Fixed widths of the input fields
  localparam int unsigned OpWidth    = 2;
  localparam int unsigned FieldWidth = 16;

  // Default widths of the timers and the beep counter
  localparam int unsigned DefPeriodWidth = 16;
  localparam int unsigned DefCountWidth  = 16;

  // Item opcodes; the fourth code is unused and leaves the state alone
  typedef enum logic [OpWidth-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_e;

  // Result of one item
  typedef struct packed {
    logic buzzer_on;
    logic start_taken;
  } bpg_res_t;

  // Timer status, for checks in the top level
  typedef struct packed {
    logic pin;
    logic on_busy;
  } bpg_stat_t;

endpackage

`default_nettype wire

// File: rtl/bpg_timer.sv
// Pattern state (on/off timers, reload lengths, beep count, pin) and its update.
// Depends on bpg_pkg.
`default_nettype none

module bpg_timer #(
  parameter int unsigned PERIOD_WIDTH = 16,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  step_i,
  input  wire  [bpg_pkg::OpWidth-1:0]          op_i,
  input  wire  [bpg_pkg::FieldWidth-1:0]       on_ticks_i,
  input  wire  [bpg_pkg::FieldWidth-1:0]       off_ticks_i,
  input  wire  [bpg_pkg::FieldWidth-1:0]       repeat_count_i,
  output bpg_pkg::bpg_res_t                    res_o,
  output bpg_pkg::bpg_stat_t                   stat_o
);
  import bpg_pkg::*;

  localparam logic [PERIOD_WIDTH-1:0] POne = PERIOD_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0]  COne = COUNT_WIDTH'(1);

  logic [PERIOD_WIDTH-1:0] on_left_q, on_left_d;
  logic [PERIOD_WIDTH-1:0] off_left_q, off_left_d;
  logic [PERIOD_WIDTH-1:0] on_reload_q, on_reload_d;
  logic [PERIOD_WIDTH-1:0] off_reload_q, off_reload_d;
  logic [COUNT_WIDTH-1:0]  beeps_left_q, beeps_left_d;
  logic                    pin_q, pin_d;

  logic [PERIOD_WIDTH-1:0] on_sat, off_sat, on_cur;
  logic [COUNT_WIDTH-1:0]  cnt_sat;
  logic                    pin_cur;
  logic                    taken;
  logic                    start_ok;
  logic                    busy;

  // Saturate start values to the configured widths
  if (PERIOD_WIDTH >= FieldWidth) begin : g_period_ext
    assign on_sat  = PERIOD_WIDTH'(on_ticks_i);
    assign off_sat = PERIOD_WIDTH'(off_ticks_i);
  end else begin : g_period_sat
    assign on_sat  = (|on_ticks_i[FieldWidth-1:PERIOD_WIDTH]) ? '1
                                                              : on_ticks_i[PERIOD_WIDTH-1:0];
    assign off_sat = (|off_ticks_i[FieldWidth-1:PERIOD_WIDTH]) ? '1
                                                               : off_ticks_i[PERIOD_WIDTH-1:0];
  end

  if (COUNT_WIDTH >= FieldWidth) begin : g_count_ext
    assign cnt_sat = COUNT_WIDTH'(repeat_count_i);
  end else begin : g_count_sat
    assign cnt_sat = (|repeat_count_i[FieldWidth-1:COUNT_WIDTH]) ? '1
                                                                 : repeat_count_i[COUNT_WIDTH-1:0];
  end

  assign start_ok = (on_left_q == '0) && (|on_ticks_i) && (|off_ticks_i) && (|repeat_count_i);
  assign busy     = (on_left_q != '0) || (off_left_q != '0) || (beeps_left_q != '0);

  // Next state for the current item
  always_comb begin
    on_left_d    = on_left_q;
    off_left_d   = off_left_q;
    on_reload_d  = on_reload_q;
    off_reload_d = off_reload_q;
    beeps_left_d = beeps_left_q;
    pin_d        = pin_q;
    on_cur       = on_left_q;
    pin_cur      = pin_q;
    taken        = 1'b0;
    case (op_i)
      OP_TICK: begin
        if (off_left_q > POne) begin
          // still silent
          off_left_d = off_left_q - POne;
        end else begin
          // end of off phase restarts the on timer in the same tick
          if (off_left_q == POne) begin
            on_cur     = on_reload_q;
            pin_cur    = 1'b1;
            off_left_d = '0;
          end
          on_left_d = on_cur;
          pin_d     = pin_cur;
          if (on_cur == POne) begin
            // end of beep
            on_left_d = '0;
            pin_d     = 1'b0;
            if (beeps_left_q == COne) begin
              beeps_left_d = '0;
            end else if (beeps_left_q != '0) begin
              off_left_d   = off_reload_q;
              beeps_left_d = beeps_left_q - COne;
            end
          end else if (on_cur != '0) begin
            on_left_d = on_cur - POne;
          end
        end
      end
      OP_START: begin
        if (start_ok) begin
          on_reload_d  = on_sat;
          on_left_d    = on_sat;
          off_reload_d = off_sat;
          off_left_d   = '0;
          beeps_left_d = cnt_sat;
          pin_d        = 1'b1;
          taken        = 1'b1;
        end
      end
      OP_STOP: begin
        if (busy) begin
          on_left_d    = '0;
          off_left_d   = '0;
          beeps_left_d = '0;
          pin_d        = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // State registers, updated once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_left_q    <= '0;
      off_left_q   <= '0;
      on_reload_q  <= '0;
      off_reload_q <= '0;
      beeps_left_q <= '0;
      pin_q        <= 1'b0;
    end else if (step_i) begin
      on_left_q    <= on_left_d;
      off_left_q   <= off_left_d;
      on_reload_q  <= on_reload_d;
      off_reload_q <= off_reload_d;
      beeps_left_q <= beeps_left_d;
      pin_q        <= pin_d;
    end
  end

  assign res_o.buzzer_on   = pin_d;
  assign res_o.start_taken = taken;
  assign stat_o.pin        = pin_q;
  assign stat_o.on_busy    = (on_left_q != '0);

endmodule

`default_nettype wire

// File: rtl/beep_pattern_generator.sv
// Channel    | Direction | Handshake                 | Payload
// input item | in        | in_valid_i / in_ready_o   | op_i, on_ticks_i, off_ticks_i, repeat_count_i
// result     | out       | out_valid_o / out_ready_i | buzzer_on_o, start_taken_o
//
// One item per clock sustained while the result register is not stalled; a result passes
// through the input register, then the timer update into the result register, and is
// then offered on the result channel.
// The timer state updates in the same cycle the result register loads.
// Reset clears the valid flags and the timer state: pin low, timers idle, reload lengths zero.
// A stalled result register stops the input register; one more item can still wait there.
//
// Top level of the beep pattern generator. Depends on bpg_pkg and bpg_timer.
`default_nettype none

module beep_pattern_generator #(
  parameter int unsigned PERIOD_WIDTH = bpg_pkg::DefPeriodWidth,
  parameter int unsigned COUNT_WIDTH  = bpg_pkg::DefCountWidth
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire  [bpg_pkg::OpWidth-1:0]     op_i,
  input  wire  [bpg_pkg::FieldWidth-1:0]  on_ticks_i,
  input  wire  [bpg_pkg::FieldWidth-1:0]  off_ticks_i,
  input  wire  [bpg_pkg::FieldWidth-1:0]  repeat_count_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic                            buzzer_on_o,
  output logic                            start_taken_o
);
  import bpg_pkg::*;

  logic                  in_valid_q;
  logic [OpWidth-1:0]    op_q;
  logic [FieldWidth-1:0] on_ticks_q;
  logic [FieldWidth-1:0] off_ticks_q;
  logic [FieldWidth-1:0] repeat_count_q;

  logic                  out_valid_q;
  bpg_res_t              res_q;
  bpg_res_t              res;
  bpg_stat_t             stat;

  logic                  out_free;
  logic                  step;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q           <= op_i;
      on_ticks_q     <= on_ticks_i;
      off_ticks_q    <= off_ticks_i;
      repeat_count_q <= repeat_count_i;
    end
  end

  bpg_timer #(
    .PERIOD_WIDTH (PERIOD_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_timer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .op_i           (op_q),
    .on_ticks_i     (on_ticks_q),
    .off_ticks_i    (off_ticks_q),
    .repeat_count_i (repeat_count_q),
    .res_o          (res),
    .stat_o         (stat)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign buzzer_on_o   = res_q.buzzer_on;
  assign start_taken_o = res_q.start_taken;

`ifndef SYNTHESIS
  // a processed item always shows up in the result register next cycle
  a_step_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("processed item did not reach the result register");

  // a pending result reports the live pin level
  a_out_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (buzzer_on_o == stat.pin))
    else $error("result pin level differs from timer pin");

  // the pin only sounds while the on timer runs
  a_pin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pin |-> stat.on_busy)
    else $error("pin high with on timer idle");

  // a taken start always sounds the buzzer
  a_start_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && start_taken_o) |-> buzzer_on_o)
    else $error("start taken without pin high");
`endif

endmodule

`default_nettype wire
